// File: design/icdg_pkg.sv
// icdg_pkg: shared constants for the central difference gradient block
// field widths, register indexes, reset values and result slot numbers
// no dependencies
`default_nettype none

package icdg_pkg;

  // fixed field widths
  localparam int ROW_W      = 12;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // register reset values
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // result slots of one pixel, in emission order
  localparam int NUM_RES    = 4;
  localparam int RES_DIAG   = 0;  // row above, column to the left
  localparam int RES_ABOVE  = 1;  // row above, this column (row end)
  localparam int RES_LEFT   = 2;  // this row, column to the left (last row)
  localparam int RES_HERE   = 3;  // this row, this column (last row, row end)

endpackage

`default_nettype wire

// File: design/image_central_difference_gradient.sv
// Throughput: one pixel per cycle while out_stall_i is low and each pixel yields at most one
//   result; a pixel yielding more (up to 2 at row ends, up to 4 on the last row) holds the
//   stage and stalls the input until its last result is emitted, as the single output
//   register takes one result per cycle.
// Reset: counters and the pixel tails clear, frame_width 640, frame_height 480;
//   the line memory is not cleared and holds nothing valid until the first row is written.
`default_nettype none

module image_central_difference_gradient
  import icdg_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i,
  // pixel input
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [PIXEL_BITS-1:0]         pixel_i,
  // gradient output
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [PIXEL_BITS+1:0]       grad_horizontal_o,
  output logic signed [PIXEL_BITS+1:0]       grad_vertical_o,
  output logic [ROW_W-1:0]                   out_row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       out_col_o,
  output logic                               last_in_run_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int GW     = PIXEL_BITS + 2;
  localparam int WORD_W = 2 * PIXEL_BITS;
  localparam int WIDTH_RESET = (MAX_WIDTH < FRAME_WIDTH_RST) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam logic [COL_W-1:0] WIDTH_LAST_RST  = COL_W'(WIDTH_RESET - 1);
  localparam logic [ROW_W-1:0] HEIGHT_LAST_RST = ROW_W'(FRAME_HEIGHT_RST - 1);
  localparam logic [31:0]      MAX_WIDTH_U     = 32'(MAX_WIDTH);

  // signed difference and doubled difference of two pixels
  function automatic logic signed [GW-1:0] pdiff(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b);
    logic signed [GW-1:0] ea;
    logic signed [GW-1:0] eb;
    ea = $signed({2'b00, a});
    eb = $signed({2'b00, b});
    return ea - eb;
  endfunction

  function automatic logic signed [GW-1:0] pdiff2(input logic [PIXEL_BITS-1:0] a,
                                                  input logic [PIXEL_BITS-1:0] b);
    logic signed [GW-1:0] d;
    d = pdiff(a, b);
    return d <<< 1;
  endfunction

  // configuration registers, kept as last column and last row
  logic [COL_W-1:0]  width_last_q, width_last_d;
  logic [ROW_W-1:0]  height_last_q, height_last_d;
  logic [FW_W-1:0]   cfg_w;
  logic [FH_W-1:0]   cfg_h;

  // position counters
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;

  // stage 1: pixel context while the line memory answers
  logic                    s1_valid_q;
  logic [PIXEL_BITS-1:0]   s1_pix_q;
  logic [COL_W-1:0]        s1_col_q;
  logic [ROW_W-1:0]        s1_row_q;
  logic                    s1_c1_q, s1_c2_q, s1_r1_q, s1_r2_q;
  logic [NUM_RES-1:0]      pending_q, pending_d, rest;

  // line memory: upper half row above, lower half two rows above
  logic [WORD_W-1:0]       line_mem [MAX_WIDTH];
  logic [WORD_W-1:0]       rd_word_q, fwd_word_q, line_word, wr_word;
  logic                    fwd_q;
  logic [PIXEL_BITS-1:0]   r1c, r2c;

  // neighbors from the previous pixel
  logic [PIXEL_BITS-1:0]   r1m1_q, r1m2_q, r2m1_q;
  logic [PIXEL_BITS-1:0]   tail0_q, tail1_q;

  // output register
  logic                    out_valid_q;
  logic signed [GW-1:0]    out_gh_q, out_gv_q;
  logic [ROW_W-1:0]        out_row_q;
  logic [COL_W-1:0]        out_col_q;
  logic                    out_last_q;

  logic accept, out_load, emit, s1_done;
  logic row_end, last_row;
  logic [NUM_RES-1:0] new_pending;

  logic signed [GW-1:0] gh_sel, gv_sel;
  logic [ROW_W-1:0]     row_sel;
  logic [COL_W-1:0]     col_sel;
  logic signed [GW-1:0] gh_diag, gv_diag, gh_above, gv_above;
  logic signed [GW-1:0] gh_left, gv_left, gh_here, gv_here;

  // config decode with clamping of zero values and of an oversize width
  assign cfg_ready_o = 1'b1;
  assign cfg_w = cfg_data_i[FW_W-1:0];
  assign cfg_h = cfg_data_i[FH_W-1:0];

  always_comb begin
    if (cfg_w == '0) begin
      width_last_d = '0;
    end else if (32'(cfg_w) > MAX_WIDTH_U) begin
      width_last_d = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_last_d = COL_W'(cfg_w - 1'b1);
    end
    if (cfg_h == '0) begin
      height_last_d = '0;
    end else begin
      height_last_d = ROW_W'(cfg_h - 1'b1);
    end
  end

  // handshake and stage control
  assign out_load   = !out_valid_q || !out_stall_i;
  assign rest       = pending_q & (pending_q - 1'b1);
  assign emit       = s1_valid_q && (pending_q != '0) && out_load;
  assign s1_done    = s1_valid_q && ((pending_q == '0) || (out_load && (rest == '0)));
  assign in_stall_o = s1_valid_q && !s1_done;
  assign accept     = in_valid_i && !in_stall_o;

  // position decode and result slots of the incoming pixel
  assign row_end  = col_q >= width_last_q;
  assign last_row = row_q >= height_last_q;

  always_comb begin
    new_pending            = '0;
    new_pending[RES_DIAG]  = (row_q != '0) && (col_q != '0);
    new_pending[RES_ABOVE] = row_end && (row_q != '0);
    new_pending[RES_LEFT]  = last_row && (col_q != '0);
    new_pending[RES_HERE]  = last_row && row_end;
  end

  always_comb begin
    if (row_end) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
      row_d = row_q;
    end
  end

  always_comb begin
    if (accept) begin
      pending_d = new_pending;
    end else if (emit) begin
      pending_d = rest;
    end else begin
      pending_d = pending_q;
    end
  end

  // memory word with forwarding of a same-cycle write
  assign line_word = fwd_q ? fwd_word_q : rd_word_q;
  assign r1c       = line_word[WORD_W-1:PIXEL_BITS];
  assign r2c       = line_word[PIXEL_BITS-1:0];
  assign wr_word   = {s1_pix_q, r1c};

  // gradients of the four result slots
  always_comb begin
    gh_diag  = s1_c2_q ? pdiff(r1c, r1m2_q) : pdiff2(r1c, r1m1_q);
    gv_diag  = s1_r2_q ? pdiff(tail0_q, r2m1_q) : pdiff2(tail0_q, r1m1_q);
    gh_above = s1_c1_q ? pdiff2(r1c, r1m1_q) : '0;
    gv_above = s1_r2_q ? pdiff(s1_pix_q, r2c) : pdiff2(s1_pix_q, r1c);
    gh_left  = s1_c2_q ? pdiff(s1_pix_q, tail1_q) : pdiff2(s1_pix_q, tail0_q);
    gv_left  = s1_r1_q ? pdiff2(tail0_q, r1m1_q) : '0;
    gh_here  = s1_c1_q ? pdiff2(s1_pix_q, tail0_q) : '0;
    gv_here  = s1_r1_q ? pdiff2(s1_pix_q, r1c) : '0;
  end

  // pick the lowest pending slot
  always_comb begin
    if (pending_q[RES_DIAG]) begin
      gh_sel  = gh_diag;
      gv_sel  = gv_diag;
      row_sel = s1_row_q - 1'b1;
      col_sel = s1_col_q - 1'b1;
    end else if (pending_q[RES_ABOVE]) begin
      gh_sel  = gh_above;
      gv_sel  = gv_above;
      row_sel = s1_row_q - 1'b1;
      col_sel = s1_col_q;
    end else if (pending_q[RES_LEFT]) begin
      gh_sel  = gh_left;
      gv_sel  = gv_left;
      row_sel = s1_row_q;
      col_sel = s1_col_q - 1'b1;
    end else begin
      gh_sel  = gh_here;
      gv_sel  = gv_here;
      row_sel = s1_row_q;
      col_sel = s1_col_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q  <= WIDTH_LAST_RST;
      height_last_q <= HEIGHT_LAST_RST;
      col_q         <= '0;
      row_q         <= '0;
      s1_valid_q    <= 1'b0;
      pending_q     <= '0;
      fwd_q         <= 1'b0;
      tail0_q       <= '0;
      tail1_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:  width_last_q  <= width_last_d;
          REG_FRAME_HEIGHT: height_last_q <= height_last_d;
          default: ;
        endcase
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        fwd_q <= s1_done && (col_q == s1_col_q);
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      pending_q <= pending_d;
      if (s1_done) begin
        tail0_q <= s1_pix_q;
        tail1_q <= tail0_q;
      end
      if (out_load) begin
        out_valid_q <= emit;
      end
    end
  end

  // line memory, read on request, written back as the pixel retires
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_word_q <= line_mem[col_q];
    end
    if (s1_done) begin
      line_mem[s1_col_q] <= wr_word;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pixel_i;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_c1_q    <= col_q != '0;
      s1_c2_q    <= col_q > COL_W'(1);
      s1_r1_q    <= row_q != '0;
      s1_r2_q    <= row_q > ROW_W'(1);
      fwd_word_q <= wr_word;
    end
    if (s1_done) begin
      r1m1_q <= r1c;
      r1m2_q <= r1m1_q;
      r2m1_q <= r2c;
    end
    if (emit) begin
      out_gh_q   <= gh_sel;
      out_gv_q   <= gv_sel;
      out_row_q  <= row_sel;
      out_col_q  <= col_sel;
      out_last_q <= rest == '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign grad_horizontal_o = out_gh_q;
  assign grad_vertical_o   = out_gv_q;
  assign out_row_o         = out_row_q;
  assign out_col_o         = out_col_q;
  assign last_in_run_o     = out_last_q;

  // no leftover results once the stage is empty
  a_pending_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> pending_q == '0)
    else $error("results pending with empty stage");

  // forwarding is only armed by a request that retires the stage in the same cycle
  a_fwd_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !s1_done) |=> !fwd_q)
    else $error("forward flag without same-cycle write");

  // a new pixel enters only as the previous one retires
  a_accept_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_valid_q) |-> s1_done)
    else $error("pixel accepted over a busy stage");

  // the final result of a pixel retires the stage
  a_last_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (rest == '0)) |-> s1_done)
    else $error("final result without retire");

endmodule

`default_nettype wire

// File: test/image_central_difference_gradient_tb.sv
// image_central_difference_gradient_tb: self-checking bench for the central difference gradient
// block, with a scoreboard class that predicts each pixel's gradients and matches the output
// depends on icdg_pkg and image_central_difference_gradient
module image_central_difference_gradient_tb
  import icdg_pkg::*;
();

  localparam int MAX_W         = 1024;
  localparam int HALF_UNIT     = 2;
  localparam int RANDOM_PIXELS = 230;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 4000;

  typedef struct packed {
    logic [9:0]       horiz;
    logic [9:0]       vert;
    logic [ROW_W-1:0] row;
    logic [9:0]       col;
    logic             last;
  } gradient_t;

  typedef enum int {PIX_NOISE, PIX_BINARY, PIX_RAMP} pixel_style_e;

  // predicts gradients per pixel and holds those still due from the block
  class gradient_checker;
    bit [7:0]      row_above [MAX_W];
    bit [7:0]      row_two_above [MAX_W];
    int unsigned   col_pos;
    int unsigned   row_pos;
    bit [7:0]      tail_near;
    bit [7:0]      tail_far;
    bit [FW_W-1:0] width_reg;
    bit [FH_W-1:0] height_reg;
    gradient_t     due_gradients[$];
    int unsigned   pixel_count;
    int unsigned   result_count;
    int unsigned   four_result_count;
    int unsigned   error_count;

    function new();
      width_reg  = FW_W'(FRAME_WIDTH_RST);
      height_reg = FH_W'(FRAME_HEIGHT_RST);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int value);
      if (idx == REG_FRAME_WIDTH) width_reg = value[FW_W-1:0];
      else height_reg = value[FH_W-1:0];
    endfunction

    // central difference in half units, one-sided at edges, zero with no neighbor
    function int half_unit_diff(int prior, int mid, int next, bit has_prior, bit has_next);
      if (has_prior && has_next) return next - prior;
      if (has_next) return HALF_UNIT * (next - mid);
      if (has_prior) return HALF_UNIT * (mid - prior);
      return 0;
    endfunction

    function gradient_t make_gradient(int gh, int gv, int r, int c);
      gradient_t g;
      g.horiz = gh[9:0];
      g.vert  = gv[9:0];
      g.row   = r[ROW_W-1:0];
      g.col   = c[9:0];
      g.last  = 1'b0;
      return g;
    endfunction

    // shift a column of the line stores
    function void store_column(int c, bit [7:0] value);
      row_two_above[c] = row_above[c];
      row_above[c]     = value;
    endfunction

    function void take_pixel(bit [7:0] pix);
      gradient_t run[$];
      gradient_t g;
      int        w, h, c, r, near, far, lft;
      bit        row_end, last_row;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : int'(width_reg);
      h = (height_reg == 0) ? 1 : int'(height_reg);
      c = (col_pos >= MAX_W) ? MAX_W - 1 : int'(col_pos);
      r = int'(row_pos);
      near = tail_near;
      far  = tail_far;
      row_end  = c >= w - 1;
      last_row = r >= h - 1;
      pixel_count++;

      // row above, column to the left
      if (r >= 1 && c >= 1) begin
        lft = (c >= 2) ? row_two_above[c-2] : 0;
        run.insert(run.size(), make_gradient(
          half_unit_diff(lft, row_above[c-1], row_above[c], c >= 2, 1'b1),
          half_unit_diff(row_two_above[c-1], row_above[c-1], near, r >= 2, 1'b1),
          r - 1, c - 1));
      end
      if (c >= 1) store_column(c - 1, tail_near);

      // row above, this column, at the row end
      if (row_end) begin
        if (r >= 1) begin
          lft = (c >= 1) ? row_two_above[c-1] : 0;
          run.insert(run.size(), make_gradient(
            half_unit_diff(lft, row_above[c], 0, c >= 1, 1'b0),
            half_unit_diff(row_two_above[c], row_above[c], pix, r >= 2, 1'b1),
            r - 1, c));
        end
        store_column(c, pix);
      end

      // bottom row drains itself
      if (last_row) begin
        if (c >= 1)
          run.insert(run.size(), make_gradient(
            half_unit_diff(far, near, pix, c >= 2, 1'b1),
            half_unit_diff(row_two_above[c-1], near, 0, r >= 1, 1'b0),
            r, c - 1));
        if (row_end)
          run.insert(run.size(), make_gradient(
            half_unit_diff(near, pix, 0, c >= 1, 1'b0),
            half_unit_diff(row_two_above[c], pix, 0, r >= 1, 1'b0),
            r, c));
      end

      tail_far  = tail_near;
      tail_near = pix;
      if (row_end) begin
        col_pos = 0;
        row_pos = last_row ? 0 : (r + 1) & 12'hFFF;
      end else begin
        col_pos = c + 1;
      end

      if (run.size() == NUM_RES) four_result_count++;
      foreach (run[i]) begin
        g = run[i];
        g.last = (i == run.size() - 1);
        due_gradients.insert(due_gradients.size(), g);
      end
    endfunction

    function void field_ok(string name, int want, int got, gradient_t ref_pos);
      if (want != got) begin
        $display("%0t: %s mismatch at row %0d col %0d: expected %0d got %0d",
                 $time, name, ref_pos.row, ref_pos.col, want, got);
        error_count++;
      end
    endfunction

    function void match_gradient(gradient_t got);
      gradient_t want;
      if (due_gradients.size() == 0) begin
        $display("%0t: unexpected gradient at row %0d col %0d", $time, got.row, got.col);
        error_count++;
        return;
      end
      want = due_gradients.pop_front();
      result_count++;
      field_ok("grad_horizontal", want.horiz, got.horiz, want);
      field_ok("grad_vertical", want.vert, got.vert, want);
      field_ok("out_row", want.row, got.row, want);
      field_ok("out_col", want.col, got.col, want);
      field_ok("last_in_run", want.last, got.last, want);
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [7:0]                 pixel_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [9:0]          grad_horizontal_o;
  logic signed [9:0]          grad_vertical_o;
  logic [ROW_W-1:0]           out_row_o;
  logic [9:0]                 out_col_o;
  logic                       last_in_run_o;

  gradient_checker grad_chk = new();
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int frame_setups = 0;

  image_central_difference_gradient u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .pixel_i           (pixel_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .grad_horizontal_o (grad_horizontal_o),
    .grad_vertical_o   (grad_vertical_o),
    .out_row_o         (out_row_o),
    .out_col_o         (out_col_o),
    .last_in_run_o     (last_in_run_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mostly short holds, now and then a long one
  function automatic int random_hold();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
  endfunction

  function automatic int random_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [7:0] frame_pixel(pixel_style_e style, int idx);
    case (style)
      PIX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_RAMP: return 8'((idx * 9 + $urandom_range(0, 4)) & 255);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // output stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left <= random_hold() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // output monitor
  always @(posedge clk_i) begin : watch_output
    gradient_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.horiz = grad_horizontal_o;
      seen.vert  = grad_vertical_o;
      seen.row   = out_row_o;
      seen.col   = out_col_o;
      seen.last  = last_in_run_o;
      grad_chk.match_gradient(seen);
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
    $display("image_central_difference_gradient_tb NOT OK");
    $finish;
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (grad_chk.due_gradients.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both frame registers once the block is idle
  task automatic configure(int w, int h);
    wait_drained();
    gap_pct   = random_pct();
    stall_pct = random_pct();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i  <= w[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    grad_chk.set_reg(REG_FRAME_WIDTH, w);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i  <= h[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    grad_chk.set_reg(REG_FRAME_HEIGHT, h);
    cfg_valid_i <= 1'b0;
    frame_setups++;
  endtask

  task automatic send_pixel(logic [7:0] px);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? random_hold() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    do @(posedge clk_i); while (in_stall_o);
    grad_chk.take_pixel(px);
  endtask

  initial begin
    int           w, h;
    int           random_sent;
    pixel_style_e style;

    random_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single pixel frames, also with zero sizes read as one
    configure(1, 1);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    configure(0, 0);
    send_pixel(8'hAA);

    // checkerboard drives the gradients to both extremes
    configure(3, 3);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'hFF : 8'h00);

    // smallest frame with top, bottom, left and right edges all present
    configure(2, 2);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'hFF);

    // single column and single row
    configure(1, 3);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h55);
    configure(3, 1);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h80);

    // widest row; mid-row the width goes above the maximum and the height to zero,
    // then a narrow width ends the row at the current column
    configure(1024, 1);
    for (int i = 0; i < 96; i++) send_pixel(frame_pixel(PIX_NOISE, i));
    configure(2047, 0);
    for (int i = 0; i < 96; i++) send_pixel(frame_pixel(PIX_NOISE, i));
    configure(3, 1);
    send_pixel(frame_pixel(PIX_NOISE, 0));

    // tallest setting, cut short mid-frame, then a narrower row ends the frame
    configure(5, 4095);
    for (int i = 0; i < 15; i++) send_pixel(frame_pixel(PIX_NOISE, i));
    configure(5, 2);
    send_pixel(frame_pixel(PIX_NOISE, 0));
    send_pixel(frame_pixel(PIX_NOISE, 1));
    configure(2, 2);
    send_pixel(frame_pixel(PIX_NOISE, 2));

    // random frames, mostly small
    while (random_sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0: w = 1;
        1: w = 2;
        7, 8: w = $urandom_range(9, 32);
        9: w = $urandom_range(33, 200);
        default: w = $urandom_range(3, 8);
      endcase
      case ($urandom_range(0, 9))
        0: h = 1;
        1: h = 2;
        8, 9: h = $urandom_range(7, 12);
        default: h = $urandom_range(3, 6);
      endcase
      if (w * h > 240) h = 240 / w;
      if (h < 1) h = 1;
      configure((w == 1 && $urandom_range(0, 3) == 0) ? 0 : w,
                (h == 1 && $urandom_range(0, 3) == 0) ? 0 : h);
      style = pixel_style_e'($urandom_range(0, 2));
      for (int i = 0; i < w * h; i++) send_pixel(frame_pixel(style, i));
      random_sent += w * h;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d pixels over %0d frame settings, %0d gradients compared",
             grad_chk.pixel_count, frame_setups, grad_chk.result_count);
    $display("%0d pixels produced four gradients, %0d mismatches",
             grad_chk.four_result_count, grad_chk.error_count);
    if (grad_chk.error_count == 0 && grad_chk.due_gradients.size() == 0)
      $display("image_central_difference_gradient_tb OK");
    else
      $display("image_central_difference_gradient_tb NOT OK");
    $finish;
  end

endmodule
